>>> src/gbn_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sequence arithmetic for the Go-Back-N link controller.
// Depends on nothing; used by gbn_ctrl, gbn_dp and go_back_n_link_controller.
package gbn_pkg;

  // Sequence space and field widths
  localparam int MAX_SEQ_NUM   = 7;
  localparam int PAYLOAD_BYTES = 5;
  localparam int SEQ_MOD       = MAX_SEQ_NUM + 1;
  localparam int SEQ_W         = 3;
  localparam int CNT_W         = 4;
  localparam int PAY_W         = 40;
  localparam int MODE_W        = 2;
  localparam int ACT_W         = 2;

  // Event codes
  localparam logic [MODE_W-1:0] MODE_NEW     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FRAME   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CKSUM   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd3;

  // Result action codes
  localparam logic [ACT_W-1:0] ACT_TX      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELIVER = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STATUS  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_REFUSE  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PAY_W-1:0]  payload;
    logic [SEQ_W-1:0]  frame_seq;
    logic [SEQ_W-1:0]  frame_ack;
  } gbn_in_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [SEQ_W-1:0] out_seq;
    logic [SEQ_W-1:0] out_ack;
    logic [PAY_W-1:0] out_payload;
    logic             window_full;
    logic             last;
  } gbn_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic do_new;
    logic do_refuse;
    logic do_status;
    logic frame_begin;
    logic release_one;
    logic frame_done;
    logic rtx_begin;
    logic rtx_emit;
  } gbn_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic none_outstanding;
    logic release_ok;
    logic rtx_last;
  } gbn_sts_t;

  // Next sequence number, wrapping after MAX_SEQ_NUM
  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] k);
    return (k < SEQ_W'(MAX_SEQ_NUM)) ? SEQ_W'(k + SEQ_W'(1)) : '0;
  endfunction

  // Piggybacked ack: one before the expected receive number
  function automatic logic [SEQ_W-1:0] cur_ack(input logic [SEQ_W-1:0] r);
    return (r == '0) ? SEQ_W'(MAX_SEQ_NUM) : SEQ_W'(r - SEQ_W'(1));
  endfunction

  // Circular check lo <= x < hi
  function automatic logic in_window(input logic [SEQ_W-1:0] lo,
                                     input logic [SEQ_W-1:0] x,
                                     input logic [SEQ_W-1:0] hi);
    return ((lo <= x) && (x < hi)) || ((hi < lo) && (lo <= x)) ||
           ((x < hi) && (hi < lo));
  endfunction

  // Window full once outstanding frames reach the limit
  function automatic logic full_of(input logic [CNT_W-1:0] n);
    return n >= CNT_W'(MAX_SEQ_NUM);
  endfunction

endpackage

>>> src/go_back_n_link_controller.sv
`timescale 1ns / 1ps
// Go-Back-N link controller with 3-bit sequence numbers, window of seven.
// A new packet, a checksum error or a timeout with nothing outstanding gives its single
// registered result the cycle after it is taken. An arrived frame holds busy while its
// ack releases outstanding frames one at a time, then gives its result. A timeout
// with n frames outstanding gives n retransmits, one per cycle, read from the send
// store's registered port, and holds busy until the last. Results are one-cycle
// strobes on out_valid that the receiver must take; last marks the final one.
// Depends on gbn_pkg, gbn_ctrl and gbn_dp.
module go_back_n_link_controller
  import gbn_pkg::*;
#(
  parameter int PAY_BYTES = PAYLOAD_BYTES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  gbn_in_t  in_item,
  output logic     out_valid,
  output gbn_out_t out_item
);

  gbn_cmd_t cmd;
  gbn_sts_t sts;

  gbn_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_item.mode),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  gbn_dp #(
    .PAY_BYTES (PAY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> src/gbn_ctrl.sv
`timescale 1ns / 1ps
// Event sequencer of the Go-Back-N link controller: accepts events and steps
// the ack release loop and retransmit bursts. Depends on gbn_pkg.
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MODE_W-1:0] mode,
  input  gbn_sts_t          sts,
  output logic              busy,
  output gbn_cmd_t          cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACK  = 2'd1;
  localparam logic [1:0] ST_RTX  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Decode events and walk the multi-cycle ones
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_NEW: begin
              cmd.do_new    = !sts.full;
              cmd.do_refuse = sts.full;
            end
            MODE_FRAME: begin
              cmd.frame_begin = 1'b1;
              state_nxt       = ST_ACK;
            end
            MODE_TIMEOUT: begin
              if (sts.none_outstanding) begin
                cmd.do_status = 1'b1;
              end else begin
                cmd.rtx_begin = 1'b1;
                state_nxt     = ST_RTX;
              end
            end
            default: begin
              cmd.do_status = 1'b1;
            end
          endcase
        end
      end
      ST_ACK: begin
        // release one frame a cycle, then report
        if (sts.release_ok) begin
          cmd.release_one = 1'b1;
        end else begin
          cmd.frame_done = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_RTX: begin
        cmd.rtx_emit = 1'b1;
        if (sts.rtx_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  ctrl_ack_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACK) |-> $past(state_r == ST_ACK || cmd.frame_begin))
    else $error("ack loop entered without a frame event");
  ctrl_rtx_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");
  ctrl_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame_begin |=> busy)
    else $error("frame event did not hold the input off");
`endif

endmodule

>>> src/gbn_dp.sv
`timescale 1ns / 1ps
// Datapath of the Go-Back-N link controller: window registers, send store
// and result register. Depends on gbn_pkg; commanded by gbn_ctrl.
module gbn_dp
  import gbn_pkg::*;
#(
  parameter int PAY_BYTES = PAYLOAD_BYTES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  gbn_in_t  in_item,
  input  gbn_cmd_t cmd,
  output gbn_sts_t sts,
  output logic     out_valid,
  output gbn_out_t out_item
);

  localparam int STORE_W = (8 * PAY_BYTES < PAY_W) ? 8 * PAY_BYTES : PAY_W;

  logic [SEQ_W-1:0]   send_next_r, send_next_nxt;
  logic [SEQ_W-1:0]   ack_oldest_r, ack_oldest_nxt;
  logic [SEQ_W-1:0]   recv_exp_r, recv_exp_nxt;
  logic [CNT_W-1:0]   outstanding_r, outstanding_nxt;
  logic               full_flag_r, full_flag_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               deliver_r, deliver_nxt;
  logic [SEQ_W-1:0]   fack_r, fack_nxt;
  logic [STORE_W-1:0] pay_r, pay_nxt;
  logic               out_valid_r, out_valid_nxt;
  gbn_out_t           out_item_r, out_item_nxt;

  logic [STORE_W-1:0] store_mem [SEQ_MOD];
  logic [STORE_W-1:0] rd_data_r;
  logic [SEQ_W-1:0]   rd_addr;
  logic [STORE_W-1:0] in_pay;
  logic [CNT_W-1:0]   out_plus;

  assign in_pay   = in_item.payload[STORE_W-1:0];
  assign out_plus = CNT_W'(outstanding_r + CNT_W'(1));

  // Status back to the sequencer
  assign sts.full             = full_flag_r;
  assign sts.none_outstanding = (outstanding_r == '0);
  assign sts.release_ok       = (outstanding_r != '0) &&
                                in_window(ack_oldest_r, fack_r, send_next_r);
  assign sts.rtx_last         = (cnt_r == CNT_W'(1));

  // Next state of the window and the result register
  always_comb begin
    send_next_nxt   = send_next_r;
    ack_oldest_nxt  = ack_oldest_r;
    recv_exp_nxt    = recv_exp_r;
    outstanding_nxt = outstanding_r;
    full_flag_nxt   = full_flag_r;
    cnt_nxt         = cnt_r;
    deliver_nxt     = deliver_r;
    fack_nxt        = fack_r;
    pay_nxt         = pay_r;
    out_valid_nxt   = 1'b0;
    out_item_nxt    = out_item_r;
    rd_addr         = seq_inc(send_next_r);

    if (cmd.do_new) begin
      send_next_nxt            = seq_inc(send_next_r);
      outstanding_nxt          = out_plus;
      full_flag_nxt            = full_of(out_plus);
      out_valid_nxt            = 1'b1;
      out_item_nxt.action      = ACT_TX;
      out_item_nxt.out_seq     = send_next_r;
      out_item_nxt.out_ack     = cur_ack(recv_exp_r);
      out_item_nxt.out_payload = PAY_W'(in_pay);
      out_item_nxt.window_full = full_of(out_plus);
      out_item_nxt.last        = 1'b1;
    end

    if (cmd.do_refuse || cmd.do_status) begin
      full_flag_nxt            = full_of(outstanding_r);
      out_valid_nxt            = 1'b1;
      out_item_nxt.action      = cmd.do_refuse ? ACT_REFUSE : ACT_STATUS;
      out_item_nxt.out_seq     = '0;
      out_item_nxt.out_ack     = cur_ack(recv_exp_r);
      out_item_nxt.out_payload = '0;
      out_item_nxt.window_full = full_of(outstanding_r);
      out_item_nxt.last        = 1'b1;
    end

    // Hold the arrived frame and advance the receive number if its seq is the expected one
    if (cmd.frame_begin) begin
      deliver_nxt = (in_item.frame_seq == recv_exp_r);
      fack_nxt    = in_item.frame_ack;
      pay_nxt     = in_pay;
      if (in_item.frame_seq == recv_exp_r) begin
        recv_exp_nxt = seq_inc(recv_exp_r);
      end
    end

    // Drop the oldest outstanding frame
    if (cmd.release_one) begin
      outstanding_nxt = CNT_W'(outstanding_r - CNT_W'(1));
      ack_oldest_nxt  = seq_inc(ack_oldest_r);
    end

    if (cmd.frame_done) begin
      full_flag_nxt            = full_of(outstanding_r);
      out_valid_nxt            = 1'b1;
      out_item_nxt.action      = deliver_r ? ACT_DELIVER : ACT_STATUS;
      out_item_nxt.out_seq     = '0;
      out_item_nxt.out_ack     = cur_ack(recv_exp_r);
      out_item_nxt.out_payload = deliver_r ? PAY_W'(pay_r) : '0;
      out_item_nxt.window_full = full_of(outstanding_r);
      out_item_nxt.last        = 1'b1;
    end

    // Rewind to the oldest frame and fetch it
    if (cmd.rtx_begin) begin
      send_next_nxt = ack_oldest_r;
      cnt_nxt       = full_of(outstanding_r) ? CNT_W'(MAX_SEQ_NUM) : outstanding_r;
      rd_addr       = ack_oldest_r;
    end

    // Send one stored frame again while fetching the next
    if (cmd.rtx_emit) begin
      send_next_nxt            = seq_inc(send_next_r);
      cnt_nxt                  = CNT_W'(cnt_r - CNT_W'(1));
      full_flag_nxt            = full_of(outstanding_r);
      out_valid_nxt            = 1'b1;
      out_item_nxt.action      = ACT_TX;
      out_item_nxt.out_seq     = send_next_r;
      out_item_nxt.out_ack     = cur_ack(recv_exp_r);
      out_item_nxt.out_payload = PAY_W'(rd_data_r);
      out_item_nxt.window_full = full_of(outstanding_r);
      out_item_nxt.last        = (cnt_r == CNT_W'(1));
    end
  end

  // Send store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.do_new) begin
      store_mem[send_next_r] <= in_pay;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_next_r   <= '0;
      ack_oldest_r  <= '0;
      recv_exp_r    <= '0;
      outstanding_r <= '0;
      full_flag_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      send_next_r   <= send_next_nxt;
      ack_oldest_r  <= ack_oldest_nxt;
      recv_exp_r    <= recv_exp_nxt;
      outstanding_r <= outstanding_nxt;
      full_flag_r   <= full_flag_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    deliver_r  <= deliver_nxt;
    fack_r     <= fack_nxt;
    pay_r      <= pay_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  dp_outstanding_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r <= CNT_W'(MAX_SEQ_NUM))
    else $error("outstanding count beyond window limit");
  dp_full_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.window_full == full_flag_r))
    else $error("reported window flag differs from stored flag");
  dp_release_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.release_one |=> (outstanding_r == CNT_W'($past(outstanding_r) - CNT_W'(1))))
    else $error("release did not drop one outstanding frame");
  dp_rtx_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rtx_emit |-> (cnt_r != '0))
    else $error("retransmit with empty burst count");
`endif

endmodule

>>> verif/tb_go_back_n_link_controller.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Go-Back-N link controller: directed and random link events
// against an in-bench protocol predictor, with bursty sender timing. Depends on gbn_pkg and
// go_back_n_link_controller.
module tb_go_back_n_link_controller;
  import gbn_pkg::*;

  localparam int N_RANDOM = 380;
  localparam int TAIL_CYC = 16;
  localparam int WDOG_CYC = 300;

  // Protocol state as the controller should hold it
  typedef struct packed {
    logic [SEQ_W-1:0]              nxt;
    logic [SEQ_W-1:0]              oldest;
    logic [SEQ_W-1:0]              rexp;
    logic [CNT_W-1:0]              outst;
    logic                          full;
    logic [SEQ_MOD-1:0][PAY_W-1:0] store;
  } link_st_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  gbn_in_t  in_item = '0;
  logic     out_valid;
  gbn_out_t out_item;

  gbn_in_t  pend_q[$];
  gbn_out_t want_q[$];
  link_st_t gen_st = '0;
  link_st_t chk_st = '0;
  gbn_out_t step_res[SEQ_MOD];
  int       step_n;

  bit       took_item = 1'b0;
  int       idle_cyc = 0;
  int       errs = 0;
  int       n_ev[4] = '{0, 0, 0, 0};
  int       n_res = 0;
  int       n_rtx = 0;
  int       n_dlv = 0;
  int       n_ref = 0;
  int       n_full = 0;

  go_back_n_link_controller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // x lies in the circular range [lo, hi) when its distance from lo is below the range length
  function automatic logic in_win(input logic [SEQ_W-1:0] lo, input logic [SEQ_W-1:0] x,
                                  input logic [SEQ_W-1:0] hi);
    logic [SEQ_W-1:0] dx;
    logic [SEQ_W-1:0] dh;
    dx = SEQ_W'(x - lo);
    dh = SEQ_W'(hi - lo);
    return dx < dh;
  endfunction

  function automatic gbn_out_t res_of(input logic [ACT_W-1:0] act, input logic [SEQ_W-1:0] sq,
                                      input logic [SEQ_W-1:0] rexp, input logic [PAY_W-1:0] p);
    gbn_out_t r;
    r             = '0;
    r.action      = act;
    r.out_seq     = sq;
    r.out_ack     = SEQ_W'(rexp - SEQ_W'(1));
    r.out_payload = p;
    return r;
  endfunction

  // Advance the link state by one event and leave its results in step_res[0 .. step_n-1]
  function automatic void link_step(inout link_st_t s, input gbn_in_t it);
    logic hit;
    int   cnt;
    step_n = 0;
    case (it.mode)
      MODE_NEW: begin
        if (s.full) begin
          step_res[0] = res_of(ACT_REFUSE, '0, s.rexp, '0);
        end else begin
          s.store[s.nxt] = it.payload;
          s.outst        = CNT_W'(s.outst + 1);
          step_res[0]    = res_of(ACT_TX, s.nxt, s.rexp, it.payload);
          s.nxt          = SEQ_W'(s.nxt + 1);
        end
        step_n = 1;
      end
      MODE_FRAME: begin
        hit = (it.frame_seq == s.rexp);
        if (hit) s.rexp = SEQ_W'(s.rexp + 1);
        // release every frame from the oldest up to and including the ack
        for (int i = 0; i < SEQ_MOD; i++) begin
          if (s.outst != 0 && in_win(s.oldest, it.frame_ack, s.nxt)) begin
            s.outst  = CNT_W'(s.outst - 1);
            s.oldest = SEQ_W'(s.oldest + 1);
          end
        end
        step_res[0] = hit ? res_of(ACT_DELIVER, '0, s.rexp, it.payload)
                          : res_of(ACT_STATUS, '0, s.rexp, '0);
        step_n = 1;
      end
      MODE_CKSUM: begin
        step_res[0] = res_of(ACT_STATUS, '0, s.rexp, '0);
        step_n = 1;
      end
      default: begin
        // go back to the oldest unacknowledged frame and resend all outstanding
        s.nxt = s.oldest;
        cnt   = (s.outst > MAX_SEQ_NUM) ? MAX_SEQ_NUM : int'(s.outst);
        for (int i = 0; i < cnt; i++) begin
          step_res[i] = res_of(ACT_TX, s.nxt, s.rexp, s.store[s.nxt]);
          s.nxt       = SEQ_W'(s.nxt + 1);
        end
        step_n = cnt;
        if (step_n == 0) begin
          step_res[0] = res_of(ACT_STATUS, '0, s.rexp, '0);
          step_n = 1;
        end
      end
    endcase
    s.full = (s.outst >= CNT_W'(MAX_SEQ_NUM));
    for (int k = 0; k < step_n; k++) begin
      step_res[k].window_full = s.full;
      step_res[k].last        = (k == step_n - 1);
    end
  endfunction

  function automatic gbn_in_t ev(input logic [MODE_W-1:0] m, input logic [PAY_W-1:0] p,
                                 input logic [SEQ_W-1:0] sq, input logic [SEQ_W-1:0] ak);
    gbn_in_t it;
    it.mode      = m;
    it.payload   = p;
    it.frame_seq = sq;
    it.frame_ack = ak;
    return it;
  endfunction

  // Queue an event, tracking the state it leaves so later events can be shaped to it
  task automatic push_ev(input gbn_in_t it);
    link_step(gen_st, it);
    pend_q.push_back(it);
  endtask

  task automatic cmp_field(input string nm, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", nm, want, got);
      errs++;
    end
  endtask

  // Drive: bursts of items separated by random gaps, changes on the falling edge
  always @(negedge clk) begin
    static int burst_left = 4;
    static int gap_left = 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (took_item) begin
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pend_q.size() != 0) begin
        start   <= 1'b1;
        in_item <= pend_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results against the oldest expectation, predict accepted items
  always @(posedge clk) begin
    gbn_out_t want;
    gbn_in_t  acc;
    if (rst_n) begin
      took_item = start && !busy;
      if (out_valid) begin
        n_res++;
        if (want_q.size() == 0) begin
          $error("unexpected result: action %0d seq %0d", out_item.action, out_item.out_seq);
          errs++;
        end else begin
          want = want_q.pop_front();
          cmp_field("action", 64'(want.action), 64'(out_item.action));
          cmp_field("out_seq", 64'(want.out_seq), 64'(out_item.out_seq));
          cmp_field("out_ack", 64'(want.out_ack), 64'(out_item.out_ack));
          cmp_field("out_payload", 64'(want.out_payload), 64'(out_item.out_payload));
          cmp_field("window_full", 64'(want.window_full), 64'(out_item.window_full));
          cmp_field("last", 64'(want.last), 64'(out_item.last));
        end
      end
      if (took_item) begin
        acc = pend_q.pop_front();
        n_ev[acc.mode]++;
        link_step(chk_st, acc);
        for (int k = 0; k < step_n; k++) begin
          want_q.push_back(step_res[k]);
          if (acc.mode == MODE_TIMEOUT && step_res[k].action == ACT_TX) n_rtx++;
          if (step_res[k].action == ACT_DELIVER) n_dlv++;
          if (step_res[k].action == ACT_REFUSE) n_ref++;
        end
        if (chk_st.full) n_full++;
      end
      // watchdog on cycles in which no item is taken in
      idle_cyc = took_item ? 0 : idle_cyc + 1;
      if (idle_cyc >= WDOG_CYC) begin
        $display("Timeout: no item taken for %0d cycles, %0d results pending",
                 WDOG_CYC, want_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    gbn_in_t it;
    int      new_w;
    int      rest;
    int      roll;

    // Directed: empty timeout, ignored error, stray frame, fill to full, refusal,
    // full retransmit, acks outside / inside / across the wrap of the window
    push_ev(ev(MODE_TIMEOUT, '0, 3'd0, 3'd0));
    push_ev(ev(MODE_CKSUM, '1, 3'd7, 3'd7));
    push_ev(ev(MODE_FRAME, 40'hA5A5_5A5A_C3, 3'd5, 3'd3));
    push_ev(ev(MODE_NEW, '0, 3'd0, 3'd0));
    push_ev(ev(MODE_NEW, '1, 3'd7, 3'd7));
    for (int i = 0; i < 5; i++) begin
      push_ev(ev(MODE_NEW, PAY_W'(40'h01_0203_0405 << i), 3'd0, 3'd0));
    end
    push_ev(ev(MODE_NEW, 40'hDE_ADBE_EF00, 3'd0, 3'd0));
    push_ev(ev(MODE_TIMEOUT, '0, 3'd0, 3'd0));
    push_ev(ev(MODE_FRAME, '1, 3'd0, 3'd7));
    push_ev(ev(MODE_FRAME, 40'h55_5555_5555, 3'd1, 3'd2));
    push_ev(ev(MODE_FRAME, '1, 3'd7, 3'd6));
    push_ev(ev(MODE_NEW, 40'h80_0000_0001, 3'd0, 3'd0));
    push_ev(ev(MODE_NEW, 40'h7F_FFFF_FFFE, 3'd0, 3'd0));
    push_ev(ev(MODE_TIMEOUT, '0, 3'd0, 3'd0));
    push_ev(ev(MODE_FRAME, 40'hAA_AAAA_AAAA, 3'd2, 3'd0));
    push_ev(ev(MODE_TIMEOUT, '1, 3'd7, 3'd7));

    // Random: mostly well-formed frames (expected seq, ack in window), mix shifts per chunk
    new_w = 50;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 40 == 0) new_w = $urandom_range(25, 70);
      rest         = 100 - new_w;
      roll         = $urandom_range(0, 99);
      it.payload   = PAY_W'({$urandom, $urandom});
      it.frame_seq = SEQ_W'($urandom);
      it.frame_ack = SEQ_W'($urandom);
      if ($urandom_range(0, 15) == 0) it.payload = $urandom_range(0, 1) ? '1 : '0;
      if (roll < new_w) begin
        it.mode = MODE_NEW;
      end else if (roll < new_w + rest * 6 / 10) begin
        it.mode = MODE_FRAME;
        if ($urandom_range(0, 9) < 7) it.frame_seq = gen_st.rexp;
        if (gen_st.outst != 0 && $urandom_range(0, 9) < 7) begin
          it.frame_ack = SEQ_W'(gen_st.oldest + $urandom_range(0, int'(gen_st.outst) - 1));
        end
      end else if (roll < new_w + rest * 7 / 10) begin
        it.mode = MODE_CKSUM;
      end else begin
        it.mode = MODE_TIMEOUT;
      end
      push_ev(it);
    end

    // Hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pend_q.size() != 0 || want_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    $display("Events: %0d new, %0d frames, %0d checksum errors, %0d timeouts; %0d results",
             n_ev[MODE_NEW], n_ev[MODE_FRAME], n_ev[MODE_CKSUM], n_ev[MODE_TIMEOUT], n_res);
    $display("Results: %0d retransmits, %0d deliveries, %0d refusals, %0d events left it full",
             n_rtx, n_dlv, n_ref, n_full);
    if (errs == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/gbn_pkg.sv
src/gbn_ctrl.sv
src/gbn_dp.sv
src/go_back_n_link_controller.sv
verif/tb_go_back_n_link_controller.sv
